// File: hdl/stc_pkg.sv
// Package with shared constants and types for the sample-to-chunk lookup block.
package stc_pkg;
    localparam int MaxRuns = 64;
    localparam int RunAw   = $clog2(MaxRuns);
    localparam int CntW    = $clog2(MaxRuns + 1);

    typedef logic [1:0] t_action;
    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_APPEND = 2'd1;
    localparam t_action ACT_LOOKUP = 2'd2;
    localparam t_action ACT_TOTAL  = 2'd3;

    typedef logic [3:0] t_status;
    localparam t_status ST_OK       = 4'd0;
    localparam t_status ST_BEYOND   = 4'd1;
    localparam t_status ST_FIRST    = 4'd2;
    localparam t_status ST_ORDER    = 4'd3;
    localparam t_status ST_SPC      = 4'd4;
    localparam t_status ST_RUNLIM   = 4'd5;
    localparam t_status ST_BIG      = 4'd6;
    localparam t_status ST_FULL     = 4'd7;
    localparam t_status ST_CHUNKCNT = 4'd8;

    localparam logic CFG_CHUNK_COUNT = 1'b0;
    localparam logic CFG_MAX_SAMPLES = 1'b1;
endpackage

// File: hdl/sample_to_chunk_lookup_core.sv
// Sample-to-chunk run table: append, walk, and divide with one shared sequencer.
// Clear, append, and a lookup or total on an empty table or zero chunk count answer
// directly; else run 0 is read and checked for chunk one, then each stored run is read,
// its repeat count worked out, multiplied and summed, and a lookup hit ends in the divider.
// Throughput: one request at a time; the next is taken the cycle after the result is accepted.
// Reset: synchronous active low; clears the run count and chunk count and disables the limit.
module sample_to_chunk_lookup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [32:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_first_chunk,
    input  logic [31:0] i_samples_per_chunk,
    input  logic [31:0] i_description_index,
    input  logic [31:0] i_sample_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [31:0] o_chunk_index,
    output logic [31:0] o_sample_description,
    output logic [31:0] o_chunk_samples,
    output logic [31:0] o_total_samples
);
    import stc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_CHK0  = 4'd2;
    localparam logic [3:0] S_RDN   = 4'd3;
    localparam logic [3:0] S_REPS  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Run memory: one word holds start chunk, samples per chunk and description.
    logic [95:0] r_mem [MaxRuns];
    logic [95:0] r_rd;
    logic        mem_we;
    logic [RunAw-1:0] mem_wa, mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= {i_first_chunk, i_samples_per_chunk, i_description_index};
        end
        r_rd <= r_mem[mem_ra];
    end

    logic [3:0]      r_state, n_state;
    logic [CntW-1:0] r_runs;
    logic [31:0]     r_chunk_count;
    logic [32:0]     r_limit;
    logic [1:0]      r_act;
    logic [31:0]     r_sidx;
    logic [CntW-1:0] r_i;
    logic [31:0]     r_first, r_per, r_desc, r_reps;
    logic [63:0]     r_prod, r_base;
    logic            r_big;
    logic            r_found;
    logic [5:0]      r_dcnt;
    logic [31:0]     r_rem;
    logic [31:0]     r_quo;
    t_status         r_st;
    logic [31:0]     r_o_chunk, r_o_desc, r_o_spc, r_o_total;

    logic lim_off, lim_neg;
    assign lim_off = (r_limit == 33'h1_FFFF_FFFF);
    assign lim_neg = r_limit[32];

    logic last_run;
    assign last_run = ({1'b0, r_i} + 1'b1) >= {1'b0, r_runs};

    // Read address: run 0 at the start of a walk, else the run after the current one.
    assign mem_ra = (r_state == S_RD0) ? '0 : r_i[RunAw-1:0] + 1'b1;
    assign mem_wa = r_runs[RunAw-1:0];

    logic accept;
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    logic append_ok;
    assign append_ok = (r_runs < CntW'(MaxRuns)) && (i_samples_per_chunk != 0)
        && (lim_off || (!lim_neg && {1'b0, i_samples_per_chunk} <= r_limit));
    assign mem_we = accept && (i_action == ACT_APPEND) && append_ok;

    // Restoring divider step: dividend bits enter from the sample offset, MSB first.
    logic [32:0] div_sh;
    logic        div_ge;
    logic [31:0] div_sub;
    assign div_sh  = {r_rem, r_quo[31]};
    assign div_ge  = (div_sh >= {1'b0, r_o_spc});
    assign div_sub = div_sh[31:0] - r_o_spc;

    // Per-run tests: sum so far, hit on the sample, and the run limit.
    logic [63:0] acc_sum;
    logic        hit, run_over;
    assign acc_sum  = r_base + r_prod;
    assign hit      = ({32'd0, r_sidx} < acc_sum);
    assign run_over = (r_act == ACT_LOOKUP) && !lim_off && !lim_neg
        && (r_prod > {31'd0, r_limit});

    logic [31:0] hit_rel;
    assign hit_rel = r_sidx - r_base[31:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) begin
                n_state = S_OUT;
                if ((i_action == ACT_LOOKUP) || (i_action == ACT_TOTAL)) begin
                    if (r_runs != 0 && r_chunk_count != 0) n_state = S_RD0;
                end
            end
            S_RD0:   n_state = S_CHK0;
            S_CHK0:  n_state = (r_rd[95:64] != 32'd1) ? S_OUT : S_RDN;
            S_RDN:   n_state = S_REPS;
            S_REPS:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_st != ST_OK || run_over || last_run) ? S_DONE : S_RDN;
            S_DIV:   n_state = (r_dcnt == 6'd0) ? S_OUT : S_DIV;
            S_DONE:  n_state = (r_st == ST_OK && r_act == ACT_LOOKUP && r_found)
                               ? S_DIV : S_OUT;
            S_OUT:   if (o_valid && i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_runs        <= '0;
            r_chunk_count <= '0;
            r_limit       <= '1;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHUNK_COUNT) r_chunk_count <= i_cfg_data[31:0];
                else r_limit <= i_cfg_data;
            end
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_act     <= i_action;
                    r_sidx    <= i_sample_index;
                    r_i       <= '0;
                    r_base    <= '0;
                    r_big     <= 1'b0;
                    r_found   <= 1'b0;
                    r_o_chunk <= '0;
                    r_o_desc  <= '0;
                    r_o_spc   <= '0;
                    r_o_total <= '0;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            r_runs <= '0;
                            r_st   <= ST_OK;
                        end
                        ACT_APPEND: begin
                            if (r_runs >= CntW'(MaxRuns)) begin
                                r_st <= ST_FULL;
                            end else if (!append_ok) begin
                                r_st <= ST_SPC;
                            end else begin
                                r_st   <= ST_OK;
                                r_runs <= r_runs + 1'b1;
                            end
                        end
                        default: begin
                            if ((r_runs == 0 || r_chunk_count == 0)
                                && i_action == ACT_LOOKUP) r_st <= ST_BEYOND;
                            else r_st <= ST_OK;
                        end
                    endcase
                    if (n_state == S_OUT) o_valid <= 1'b1;
                end
                S_CHK0: begin
                    {r_first, r_per, r_desc} <= r_rd;
                    if (r_rd[95:64] != 32'd1) begin
                        r_st    <= ST_FIRST;
                        o_valid <= 1'b1;
                    end
                end
                S_RDN: ;
                // Next run's start is in r_rd; work out the repeat count.
                S_REPS: begin
                    if (!last_run) begin
                        if (r_rd[95:64] <= r_first) r_st <= ST_ORDER;
                        r_reps <= r_rd[95:64] - r_first;
                    end else begin
                        if (r_chunk_count < r_first) r_st <= ST_CHUNKCNT;
                        r_reps <= r_chunk_count - r_first + 32'd1;
                    end
                end
                S_MUL: r_prod <= r_per * r_reps;
                // Check the run, note a hit, sum up and step to the next run.
                S_ACC: begin
                    if (r_st == ST_OK && run_over) begin
                        r_st <= ST_RUNLIM;
                    end else if (r_st == ST_OK) begin
                        if (r_act == ACT_LOOKUP) begin
                            if (!r_found && hit) begin
                                r_found   <= 1'b1;
                                r_o_chunk <= r_first;
                                r_o_desc  <= r_desc;
                                r_o_spc   <= r_per;
                                r_quo     <= hit_rel;
                            end else if (!r_found) begin
                                r_base <= acc_sum;
                            end
                        end else if (!r_big) begin
                            r_big  <= (acc_sum > 64'hFFFF_FFFF);
                            r_base <= acc_sum;
                        end
                        if (!last_run) begin
                            r_i <= r_i + 1'b1;
                            {r_first, r_per, r_desc} <= r_rd;
                        end
                    end
                end
                // Walk finished: start the divider on a hit, else report.
                S_DONE: begin
                    if (r_st == ST_OK && r_act == ACT_LOOKUP && r_found) begin
                        r_rem  <= '0;
                        r_dcnt <= 6'd31;
                    end else begin
                        o_valid <= 1'b1;
                        if (r_st == ST_OK) begin
                            if (r_act == ACT_LOOKUP) r_st <= ST_BEYOND;
                            else if (r_big) r_st <= ST_BIG;
                            else r_o_total <= r_base[31:0];
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_sub : div_sh[31:0];
                    r_quo  <= {r_quo[30:0], div_ge};
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == 6'd0) begin
                        o_valid   <= 1'b1;
                        r_o_chunk <= r_o_chunk + {r_quo[30:0], div_ge};
                    end
                end
                S_OUT: if (o_valid && i_ready) o_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_status             = r_st;
    assign o_chunk_index        = (r_st == ST_OK) ? r_o_chunk : '0;
    assign o_sample_description = (r_st == ST_OK) ? r_o_desc : '0;
    assign o_chunk_samples      = (r_st == ST_OK) ? r_o_spc : '0;
    assign o_total_samples      = (r_st == ST_OK) ? r_o_total : '0;
endmodule

// File: bench/sample_to_chunk_lookup_core_tb.sv
// Self-checking testbench for the sample-to-chunk lookup core.
`timescale 1ns / 100ps

module sample_to_chunk_lookup_core_tb;
    import stc_pkg::*;

    localparam logic [32:0] LimOff = 33'h1FFFFFFFF;
    localparam int ItemTarget = 1850;

    typedef struct packed {
        t_status     status;
        logic [31:0] chunk;
        logic [31:0] desc;
        logic [31:0] spc;
        logic [31:0] total;
    } t_answer;

    // Scoreboard holding a copy of the run table and the answers still owed.
    class stc_scoreboard;
        logic [31:0] start_chunk [MaxRuns];
        logic [31:0] chunk_spc [MaxRuns];
        logic [31:0] run_desc [MaxRuns];
        int          run_cnt;
        logic [31:0] chunk_count;
        logic [32:0] limit;
        t_answer     owed [$];
        int          errors;

        function new();
            run_cnt = 0;
            chunk_count = 0;
            limit = LimOff;
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endfunction

        // Total samples of the table as stored, used to aim lookups at hits.
        function logic [63:0] table_span();
            logic [63:0] sum;
            logic [31:0] reps;
            sum = 0;
            for (int i = 0; i < run_cnt; i++) begin
                if (i + 1 < run_cnt) reps = start_chunk[i + 1] - start_chunk[i];
                else reps = chunk_count - start_chunk[i] + 32'd1;
                sum += 64'(chunk_spc[i]) * 64'(reps);
            end
            return sum;
        endfunction

        // Work out the answer to an accepted request and queue it.
        function void note_request(t_action act, logic [31:0] fc, logic [31:0] spc,
                                   logic [31:0] desc, logic [31:0] sidx);
            t_answer     a;
            logic        dis, neg, found, big;
            logic [63:0] base, prod;
            logic [31:0] first, per, reps;
            a = '0;
            dis = (limit == LimOff);
            neg = limit[32];
            found = 0;
            big = 0;
            base = 0;
            if (act == ACT_CLEAR) begin
                run_cnt = 0;
            end else if (act == ACT_APPEND) begin
                if (run_cnt >= MaxRuns) begin
                    a.status = ST_FULL;
                end else if (spc == 0 || (!dis && (neg || {1'b0, spc} > limit))) begin
                    a.status = ST_SPC;
                end else begin
                    start_chunk[run_cnt] = fc;
                    chunk_spc[run_cnt] = spc;
                    run_desc[run_cnt] = desc;
                    run_cnt++;
                end
            end else if (run_cnt == 0 || chunk_count == 0) begin
                a.status = (act == ACT_LOOKUP) ? ST_BEYOND : ST_OK;
            end else if (start_chunk[0] != 32'd1) begin
                a.status = ST_FIRST;
            end else begin
                for (int i = 0; i < run_cnt; i++) begin
                    first = start_chunk[i];
                    per = chunk_spc[i];
                    if (i + 1 < run_cnt) begin
                        if (start_chunk[i + 1] <= first) begin
                            a.status = ST_ORDER;
                            break;
                        end
                        reps = start_chunk[i + 1] - first;
                    end else begin
                        if (chunk_count < first) begin
                            a.status = ST_CHUNKCNT;
                            break;
                        end
                        reps = chunk_count - first + 32'd1;
                    end
                    prod = 64'(per) * 64'(reps);
                    if (act == ACT_LOOKUP) begin
                        if (!dis && !neg && prod > 64'(limit)) begin
                            a.status = ST_RUNLIM;
                            break;
                        end
                        if (!found && 64'(sidx) < base + prod) begin
                            found = 1;
                            a.chunk = 32'(64'(first) + (64'(sidx) - base) / 64'(per));
                            a.desc = run_desc[i];
                            a.spc = per;
                        end
                        if (!found) base += prod;
                    end else if (!big) begin
                        base += prod;
                        if (base > 64'hFFFFFFFF) big = 1;
                    end
                end
                if (a.status == ST_OK) begin
                    if (act == ACT_LOOKUP) begin
                        if (!found) a.status = ST_BEYOND;
                    end else if (big) begin
                        a.status = ST_BIG;
                    end else begin
                        a.total = base[31:0];
                    end
                end
                if (a.status != ST_OK) begin
                    a.chunk = 0;
                    a.desc = 0;
                    a.spc = 0;
                    a.total = 0;
                end
            end
            owed.insert(owed.size(), a);
        endfunction

        // Compare one delivered result with the oldest owed answer.
        function void check_result(t_answer got);
            t_answer want;
            if (owed.size() == 0) begin
                report("result with nothing owed, status", 64'(got.status), 0);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
            if (got.chunk !== want.chunk) report("chunk_index", 64'(got.chunk), 64'(want.chunk));
            if (got.desc !== want.desc)
                report("sample_description", 64'(got.desc), 64'(want.desc));
            if (got.spc !== want.spc) report("chunk_samples", 64'(got.spc), 64'(want.spc));
            if (got.total !== want.total)
                report("total_samples", 64'(got.total), 64'(want.total));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [32:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [31:0] i_first_chunk;
    logic [31:0] i_samples_per_chunk;
    logic [31:0] i_description_index;
    logic [31:0] i_sample_index;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_status;
    logic [31:0] o_chunk_index;
    logic [31:0] o_sample_description;
    logic [31:0] o_chunk_samples;
    logic [31:0] o_total_samples;

    stc_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;
    int n_sent = 0;

    sample_to_chunk_lookup_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // Send one request, with an optional idle burst in front of it.
    task automatic send(t_action act, logic [31:0] fc, logic [31:0] spc,
                        logic [31:0] desc, logic [31:0] sidx);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_action <= act;
        i_first_chunk <= fc;
        i_samples_per_chunk <= spc;
        i_description_index <= desc;
        i_sample_index <= sidx;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(act, fc, spc, desc, sidx);
        n_sent++;
    endtask

    // Stop sending and wait until every owed answer has come back.
    task automatic drain();
        i_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_config(logic [31:0] cc, logic [32:0] lim);
        drain();
        i_cfg_we <= 1;
        i_cfg_index <= CFG_CHUNK_COUNT;
        i_cfg_data <= {1'b0, cc};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_SAMPLES;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.chunk_count = cc;
        sb.limit = lim;
    endtask

    // Receiver: check results and stall in bursts or for one long hold-off.
    initial begin
        int hold_left, stall_left;
        bit nr;
        bit held;
        hold_left = 0;
        stall_left = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                sb.check_result({t_status'(o_status), o_chunk_index, o_sample_description,
                                 o_chunk_samples, o_total_samples});
            if (hold_req && !held) begin
                held = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 0;
            end else if (stall_left > 0) begin
                stall_left--;
                nr = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                nr = 0;
            end else begin
                nr = 1;
            end
            i_ready <= nr;
        end
    end

    initial begin
        #30_000_000;
        $display("sample_to_chunk_lookup_core_tb failed");
        $finish;
    end

    // Main sequence: directed cases, then random run tables and queries.
    initial begin
        logic [31:0] cc, fc, inc, spc;
        logic [32:0] lim;
        logic [63:0] span;
        int nruns, nq;
        bit good;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_index <= CFG_CHUNK_COUNT;
        i_cfg_data <= '0;
        i_valid <= 0;
        i_ready <= 0;
        i_action <= ACT_CLEAR;
        i_first_chunk <= 0;
        i_samples_per_chunk <= 0;
        i_description_index <= 0;
        i_sample_index <= 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Empty table, zero chunk count and an append with zero samples per chunk.
        send(ACT_LOOKUP, 0, 0, 0, 0);
        send(ACT_TOTAL, 0, 0, 0, 0);
        send(ACT_APPEND, 1, 0, 5, 0);
        send(ACT_APPEND, 1, 3, 7, 0);
        send(ACT_LOOKUP, 0, 0, 0, 0);
        // Single run: first, last and one past the last sample.
        set_config(10, LimOff);
        send(ACT_LOOKUP, 0, 0, 0, 0);
        send(ACT_LOOKUP, 0, 0, 0, 29);
        send(ACT_LOOKUP, 0, 0, 0, 30);
        send(ACT_TOTAL, 0, 0, 0, 0);
        // Repeated first chunk, first run off chunk one, chunk count too low.
        send(ACT_APPEND, 1, 2, 9, 0);
        send(ACT_LOOKUP, 0, 0, 0, 0);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_APPEND, 2, 2, 9, 0);
        send(ACT_TOTAL, 0, 0, 0, 0);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_APPEND, 1, 4, 1, 0);
        send(ACT_APPEND, 20, 2, 2, 0);
        send(ACT_TOTAL, 0, 0, 0, 0);
        // Largest values: oversized total and full-range lookup.
        set_config(32'hFFFFFFFF, 33'h0FFFFFFFF);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_APPEND, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send(ACT_TOTAL, 0, 0, 0, 0);
        send(ACT_LOOKUP, 0, 0, 0, 32'hFFFFFFFF);
        // Run over the limit, then a negative limit other than disabled.
        set_config(100, 20);
        send(ACT_CLEAR, 0, 0, 0, 0);
        send(ACT_APPEND, 1, 25, 3, 0);
        send(ACT_APPEND, 1, 5, 3, 0);
        send(ACT_LOOKUP, 0, 0, 0, 0);
        set_config(100, 33'h100000000);
        send(ACT_APPEND, 1, 1, 3, 0);
        send(ACT_LOOKUP, 0, 0, 0, 3);
        // Fill the table past its end.
        set_config(1000, LimOff);
        send(ACT_CLEAR, 0, 0, 0, 0);
        for (int i = 1; i <= MaxRuns + 1; i++) send(ACT_APPEND, i, 1, i, 0);
        send(ACT_LOOKUP, 0, 0, 0, 70);
        send(ACT_TOTAL, 0, 0, 0, 0);

        // Random phases, each with its own settings and table.
        for (int ph = 0; n_sent < ItemTarget; ph++) begin
            case ($urandom_range(0, 5))
                0: cc = 0;
                1: cc = 1;
                2: cc = 32'hFFFFFFFF;
                3: cc = $urandom;
                default: cc = $urandom_range(1, 400);
            endcase
            case ($urandom_range(0, 7))
                0: lim = 0;
                1: lim = 33'h0FFFFFFFF;
                2: lim = 33'h100000000;
                3: lim = {1'($urandom), 32'($urandom)};
                4: lim = $urandom_range(1, 5000);
                default: lim = LimOff;
            endcase
            set_config(cc, lim);
            quiet = (n_sent > ItemTarget - 200);
            if (ph == 3) hold_req = 1;
            send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
            good = ($urandom_range(0, 4) != 0);
            nruns = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MaxRuns)
                                                 : $urandom_range(1, 6);
            fc = good ? 1 : $urandom_range(0, 3);
            for (int r = 0; r < nruns; r++) begin
                spc = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 50);
                send(ACT_APPEND, fc, spc, $urandom, $urandom);
                inc = ($urandom_range(0, 7) == 0) ? $urandom :
                      (good ? $urandom_range(1, 8) : $urandom_range(0, 4));
                fc += inc;
            end
            span = sb.table_span();
            nq = $urandom_range(5, 20);
            for (int q = 0; q < nq; q++) begin
                case ($urandom_range(0, 9))
                    0: send(t_action'($urandom), $urandom, $urandom, $urandom, $urandom);
                    1, 2: send(ACT_TOTAL, $urandom, $urandom, $urandom, $urandom);
                    3: send(ACT_LOOKUP, $urandom, $urandom, $urandom, 32'(span));
                    4: send(ACT_LOOKUP, $urandom, $urandom, $urandom, $urandom);
                    default:
                        send(ACT_LOOKUP, $urandom, $urandom, $urandom,
                             (span == 0) ? 32'($urandom) : 32'({$urandom, $urandom} % span));
                endcase
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sample_to_chunk_lookup_core_tb passed");
        end else begin
            $display("sample_to_chunk_lookup_core_tb failed");
        end
        $finish;
    end
endmodule
